>>> rtl/core/dtt_pkg.sv
// Package for the deadline timer table.
// Holds command and status codes and the controller/datapath command and status types.
// No dependencies.
package dtt_pkg;

    localparam int          IDX_W          = 6;   // width of a slot number on the ports
    localparam int          MAX_OUT        = 16;  // most slots emitted by one expire
    localparam int          LIST_W         = 4;   // index into the expired-slot list
    localparam int          NLIST_W        = 5;   // count of listed slots, 0..MAX_OUT
    localparam logic [31:0] WINDOW_RESET   = 32'd3600000;
    localparam logic [63:0] NO_TIMER_DELAY = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_CANCEL  = 3'd1,
        CMD_REFRESH = 3'd2,
        CMD_RESET   = 3'd3,
        CMD_NEXT    = 3'd4,
        CMD_EXPIRE  = 3'd5,
        CMD_ANY     = 3'd6,
        CMD_UNUSED  = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOTACT  = 2'd1,
        ST_FULL    = 2'd2,
        ST_NONE    = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_ADD_WR,
        OP_CANCEL,
        OP_RD_ID,
        OP_REFRESH_WR,
        OP_RESET_START,
        OP_RESET_WR,
        OP_FS_CLR,
        OP_SCAN_CLR,
        OP_SCAN_ACT,
        OP_SCAN_DUE,
        OP_SCAN_REM,
        OP_ROLL_DIFF,
        OP_ROLL_SET,
        OP_PICK,
        OP_REARM_RD,
        OP_REARM_WR,
        OP_RES,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        RES_OK,
        RES_NOTACT,
        RES_FULL,
        RES_EMPTY,
        RES_ADD,
        RES_INS,
        RES_NEXT
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_REF_WR,
        S_RST_CHK,
        S_RST_WR,
        S_SCAN_INIT,
        S_SCAN,
        S_ROLL,
        S_DSCAN,
        S_DCHK,
        S_SEL_INIT,
        S_SEL,
        S_PICK,
        S_PCHK,
        S_RR,
        S_RW,
        S_EMIT,
        S_RES
    } t_state;

    typedef struct packed {
        t_op               op;
        logic              rd_en;
        logic [IDX_W-1:0]  idx;
        logic [LIST_W-1:0] k;
        t_res              res;
        logic              last;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0]         cmd;
        logic               id_ok;
        logic               act_id;
        logic               free_ok;
        logic               any_act;
        logic               ivl_eq;
        logic               fnow;
        logic               due_any;
        logic [NLIST_W-1:0] nlist;
        logic               out_free;
    } t_dp_sts;

endpackage

>>> rtl/core/dtt_if.sv
// Valid/ready channel interfaces for the deadline timer table.
// Command channel and result channel; no dependencies.
interface tmr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [5:0]  timer_id;
    logic [31:0] interval_ms;
    logic        recurring;
    logic        restart_now;
    logic [63:0] now_ms;

    modport source (output valid, command, timer_id, interval_ms, recurring, restart_now,
                    now_ms, input ready);
    modport sink   (input valid, command, timer_id, interval_ms, recurring, restart_now,
                    now_ms, output ready);
endinterface

interface tmr_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  slot_id;
    logic [1:0]  status;
    logic [63:0] delay_ms;
    logic        new_earliest;
    logic        any_active;
    logic        last;

    modport source (output valid, slot_id, status, delay_ms, new_earliest, any_active, last,
                    input ready);
    modport sink   (input valid, slot_id, status, delay_ms, new_earliest, any_active, last,
                    output ready);
endinterface

>>> rtl/core/deadline_timer_table.sv
// Top level of the deadline timer table: joins the controller and the datapath.
// Depends on dtt_pkg, dtt_if, dtt_ctrl and dtt_datapath.
//
// Commands arrive on i_cmd (valid/ready) and carry the current time; results leave on
// o_res, one per command, or one per expired slot for expire with last on the final one.
// i_cfg_we/i_cfg_wdata write the rollover window; write it only while the block is idle.
// One command is worked at a time. The slot deadlines sit in a memory that is scanned
// one slot per cycle; an expire lists and reports at most 16 due slots. The result sits
// in an output register, so a new command is taken while the last result of the
// previous one still waits. When the receiver stalls, an expire holds with its next
// result ready until the register frees. A synchronous reset empties the table, clears
// the time and pending signal state and restores the window to 3600000 ms.
module deadline_timer_table
    import dtt_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    tmr_in_if.sink      i_cmd,
    tmr_out_if.source   o_res
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    assign i_cmd.ready = in_ready;

    dtt_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_dp_sts   (dp_sts),
        .o_dp_cmd   (dp_cmd)
    );

    dtt_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_cmd),
        .o_res       (o_res),
        .i_dp_cmd    (dp_cmd),
        .o_dp_sts    (dp_sts)
    );

endmodule

>>> rtl/core/dtt_datapath.sv
// Datapath of the deadline timer table: slot flags, interval and deadline memories,
// scan compare, expired-slot list and the result register. Depends on dtt_pkg and dtt_if.
module dtt_datapath
    import dtt_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    tmr_in_if.sink       i_cmd,
    tmr_out_if.source    o_res,
    input  t_dp_cmd      i_dp_cmd,
    output t_dp_sts      o_dp_sts
);

    localparam int IW = $clog2(NUM_TIMERS);

    logic [63:0] dl_mem [NUM_TIMERS];
    logic [31:0] iv_mem [NUM_TIMERS];

    logic [NUM_TIMERS-1:0] r_active, r_rec, r_due;
    logic [IW-1:0]         r_list [MAX_OUT];
    logic [NLIST_W-1:0]    r_nlist;

    logic [2:0]  r_cmd;
    logic [5:0]  r_id;
    logic [31:0] r_ivl;
    logic        r_rec_in, r_fnow;
    logic [63:0] r_now;

    logic [31:0] r_window;
    logic [63:0] r_prev;
    logic        r_fs;
    logic [63:0] r_dl_q;
    logic [31:0] r_iv_q;
    logic [IW-1:0] r_q_idx;
    logic        r_q_vld;
    logic        r_best_vld;
    logic [IW-1:0] r_best_idx;
    logic [63:0] r_best_dl;
    logic [63:0] r_diff, r_start;
    logic        r_lt, r_roll;
    logic [IW-1:0] r_tgt;

    logic        r_ov;
    logic [5:0]  r_o_slot;
    logic [1:0]  r_o_st;
    logic [63:0] r_o_dly;
    logic        r_o_ne, r_o_any, r_o_last;

    logic [IW-1:0] free_idx, id_ix, list_k, rd_addr, wr_addr;
    logic          free_ok, id_ok, rd_en, load;
    logic          wr_dl_en, wr_iv_en;
    logic [63:0]   wr_dl;
    logic [31:0]   wr_iv;
    logic          mask_bit, better;
    logic [5:0]    res_slot;
    t_status       res_st;
    logic [63:0]   res_dly;
    logic          res_ne, res_last;

    assign id_ok  = {1'b0, r_id} < 7'(NUM_TIMERS);
    assign id_ix  = r_id[IW-1:0];
    assign list_k = r_list[i_dp_cmd.k];

    // lowest free slot
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        rd_en   = i_dp_cmd.rd_en;
        rd_addr = i_dp_cmd.idx[IW-1:0];
        case (i_dp_cmd.op)
            OP_RD_ID: begin
                rd_en   = 1'b1;
                rd_addr = id_ix;
            end
            OP_REARM_RD: begin
                rd_en   = 1'b1;
                rd_addr = list_k;
            end
            default: ;
        endcase
    end

    always_comb begin
        wr_dl_en = 1'b0;
        wr_iv_en = 1'b0;
        wr_addr  = id_ix;
        wr_dl    = r_now + 64'(r_iv_q);
        wr_iv    = r_ivl;
        case (i_dp_cmd.op)
            OP_ADD_WR: begin
                wr_dl_en = 1'b1;
                wr_iv_en = 1'b1;
                wr_addr  = free_idx;
                wr_dl    = r_now + 64'(r_ivl);
            end
            OP_REFRESH_WR: wr_dl_en = 1'b1;
            OP_RESET_WR: begin
                wr_dl_en = 1'b1;
                wr_iv_en = 1'b1;
                wr_dl    = r_start + 64'(r_ivl);
            end
            OP_REARM_WR: begin
                wr_dl_en = r_rec[list_k];
                wr_addr  = list_k;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_dl_en) begin
            dl_mem[wr_addr] <= wr_dl;
        end
        if (wr_iv_en) begin
            iv_mem[wr_addr] <= wr_iv;
        end
        if (rd_en) begin
            r_dl_q <= dl_mem[rd_addr];
            r_iv_q <= iv_mem[rd_addr];
        end
        r_q_idx <= i_dp_cmd.idx[IW-1:0];
    end

    assign mask_bit = (i_dp_cmd.op == OP_SCAN_ACT) ? r_active[r_q_idx] : r_due[r_q_idx];
    assign better   = mask_bit && (!r_best_vld || r_dl_q < r_best_dl);

    // result fields for the item being loaded
    always_comb begin
        res_slot = '0;
        res_st   = ST_OK;
        res_dly  = '0;
        res_ne   = 1'b0;
        res_last = 1'b1;
        if (i_dp_cmd.op == OP_EMIT) begin
            res_slot = 6'(list_k);
            res_last = i_dp_cmd.last;
        end else begin
            case (i_dp_cmd.res)
                RES_OK:     res_st = ST_OK;
                RES_NOTACT: res_st = ST_NOTACT;
                RES_FULL:   res_st = ST_FULL;
                RES_EMPTY:  res_st = ST_NONE;
                RES_ADD: begin
                    res_slot = 6'(r_tgt);
                    res_ne   = r_best_vld && r_best_idx == r_tgt && !r_fs;
                end
                RES_INS:    res_ne = r_best_vld && r_best_idx == r_tgt && !r_fs;
                RES_NEXT: begin
                    if (!r_best_vld) begin
                        res_st  = ST_NONE;
                        res_dly = NO_TIMER_DELAY;
                    end else if (r_now >= r_best_dl) begin
                        res_dly = '0;
                    end else begin
                        res_dly = r_best_dl - r_now;
                    end
                end
                default: ;
            endcase
        end
    end

    assign load = i_dp_cmd.op == OP_RES || i_dp_cmd.op == OP_EMIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_rec      <= '0;
            r_due      <= '0;
            r_nlist    <= '0;
            r_prev     <= '0;
            r_fs       <= 1'b0;
            r_window   <= WINDOW_RESET;
            r_q_vld    <= 1'b0;
            r_best_vld <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_q_vld <= i_dp_cmd.rd_en;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            case (i_dp_cmd.op)
                OP_ADD_WR: begin
                    r_active[free_idx] <= 1'b1;
                    r_rec[free_idx]    <= r_rec_in;
                end
                OP_CANCEL:  r_active[id_ix] <= 1'b0;
                OP_FS_CLR:  r_fs <= 1'b0;
                OP_SCAN_CLR: r_best_vld <= 1'b0;
                OP_SCAN_ACT, OP_SCAN_REM: begin
                    if (r_q_vld && better) begin
                        r_best_vld <= 1'b1;
                    end
                end
                OP_SCAN_DUE: begin
                    if (r_q_vld) begin
                        r_due[r_q_idx] <= r_active[r_q_idx] && (r_roll || r_dl_q <= r_now);
                    end
                end
                OP_ROLL_SET: begin
                    r_prev  <= r_now;
                    r_due   <= '0;
                    r_nlist <= '0;
                end
                OP_PICK: begin
                    r_due[r_best_idx] <= 1'b0;
                    r_nlist           <= r_nlist + 1'b1;
                end
                OP_REARM_WR: begin
                    if (!r_rec[list_k]) begin
                        r_active[list_k] <= 1'b0;
                    end
                end
                OP_RES, OP_EMIT: begin
                    if (res_ne) begin
                        r_fs <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_dp_cmd.op)
            OP_LATCH: begin
                r_cmd    <= i_cmd.command;
                r_id     <= i_cmd.timer_id;
                r_ivl    <= i_cmd.interval_ms;
                r_rec_in <= i_cmd.recurring;
                r_fnow   <= i_cmd.restart_now;
                r_now    <= i_cmd.now_ms;
            end
            OP_ADD_WR:      r_tgt <= free_idx;
            OP_RESET_WR:    r_tgt <= id_ix;
            OP_RESET_START: r_start <= r_fnow ? r_now : r_dl_q - 64'(r_iv_q);
            OP_ROLL_DIFF: begin
                r_diff <= r_prev - r_now;
                r_lt   <= r_now < r_prev;
            end
            OP_ROLL_SET:    r_roll <= r_lt && r_diff > 64'(r_window);
            OP_SCAN_ACT, OP_SCAN_REM: begin
                if (r_q_vld && better) begin
                    r_best_idx <= r_q_idx;
                    r_best_dl  <= r_dl_q;
                end
            end
            OP_PICK:        r_list[r_nlist[LIST_W-1:0]] <= r_best_idx;
            default: ;
        endcase
        if (load) begin
            r_o_slot <= res_slot;
            r_o_st   <= res_st;
            r_o_dly  <= res_dly;
            r_o_ne   <= res_ne;
            r_o_any  <= |r_active;
            r_o_last <= res_last;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.slot_id      = r_o_slot;
    assign o_res.status       = r_o_st;
    assign o_res.delay_ms     = r_o_dly;
    assign o_res.new_earliest = r_o_ne;
    assign o_res.any_active   = r_o_any;
    assign o_res.last         = r_o_last;

    assign o_dp_sts.cmd      = r_cmd;
    assign o_dp_sts.id_ok    = id_ok;
    assign o_dp_sts.act_id   = id_ok && r_active[id_ix];
    assign o_dp_sts.free_ok  = free_ok;
    assign o_dp_sts.any_act  = |r_active;
    assign o_dp_sts.ivl_eq   = r_iv_q == r_ivl;
    assign o_dp_sts.fnow     = r_fnow;
    assign o_dp_sts.due_any  = |r_due;
    assign o_dp_sts.nlist    = r_nlist;
    assign o_dp_sts.out_free = !r_ov || o_res.ready;

    a_nlist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nlist <= NLIST_W'(MAX_OUT))
        else $error("expired list overflow");

    a_add_sets_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.op == OP_ADD_WR |=> r_active[$past(free_idx)])
        else $error("added slot not active");

    a_fs_with_signal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fs) |-> r_ov && r_o_ne)
        else $error("front signal pending without a reported new earliest");

endmodule

>>> rtl/core/dtt_ctrl.sv
// Controller of the deadline timer table: command sequencer and slot scan counters.
// Drives dtt_datapath through t_dp_cmd; depends on dtt_pkg.
module dtt_ctrl
    import dtt_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_dp_sts,
    output t_dp_cmd o_dp_cmd
);

    localparam int CW = $clog2(NUM_TIMERS + 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [LIST_W-1:0] r_k, n_k;
    t_res              r_res, n_res;
    logic              scan_end, k_last;

    assign scan_end = r_cnt == CW'(NUM_TIMERS);
    assign k_last   = NLIST_W'(r_k) + 1'b1 == i_dp_sts.nlist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
            r_res   <= RES_OK;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_k        = r_k;
        n_res      = r_res;
        o_in_ready = 1'b0;
        o_dp_cmd   = '{op: OP_NONE, rd_en: 1'b0, idx: IDX_W'(r_cnt), k: r_k,
                       res: r_res, last: k_last};
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_dp_cmd.op = OP_LATCH;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RES;
                n_res   = RES_OK;
                case (i_dp_sts.cmd)
                    CMD_ADD: begin
                        if (!i_dp_sts.free_ok) begin
                            n_res = RES_FULL;
                        end else begin
                            o_dp_cmd.op = OP_ADD_WR;
                            n_state     = S_SCAN_INIT;
                        end
                    end
                    CMD_CANCEL: begin
                        if (i_dp_sts.act_id) begin
                            o_dp_cmd.op = OP_CANCEL;
                        end else begin
                            n_res = RES_NOTACT;
                        end
                    end
                    CMD_REFRESH: begin
                        if (i_dp_sts.act_id) begin
                            o_dp_cmd.op = OP_RD_ID;
                            n_state     = S_REF_WR;
                        end else begin
                            n_res = RES_NOTACT;
                        end
                    end
                    CMD_RESET: begin
                        if (i_dp_sts.id_ok) begin
                            o_dp_cmd.op = OP_RD_ID;
                            n_state     = S_RST_CHK;
                        end else begin
                            n_res = RES_NOTACT;
                        end
                    end
                    CMD_NEXT: begin
                        o_dp_cmd.op = OP_FS_CLR;
                        n_state     = S_SCAN_INIT;
                    end
                    CMD_EXPIRE: begin
                        if (!i_dp_sts.any_act) begin
                            n_res = RES_EMPTY;
                        end else begin
                            o_dp_cmd.op = OP_ROLL_DIFF;
                            n_state     = S_ROLL;
                        end
                    end
                    default: ;
                endcase
            end
            S_REF_WR: begin
                o_dp_cmd.op = OP_REFRESH_WR;
                n_res       = RES_OK;
                n_state     = S_RES;
            end
            S_RST_CHK: begin
                n_state = S_RES;
                if (i_dp_sts.ivl_eq && !i_dp_sts.fnow) begin
                    n_res = RES_OK;
                end else if (i_dp_sts.act_id) begin
                    o_dp_cmd.op = OP_RESET_START;
                    n_state     = S_RST_WR;
                end else begin
                    n_res = RES_NOTACT;
                end
            end
            S_RST_WR: begin
                o_dp_cmd.op = OP_RESET_WR;
                n_state     = S_SCAN_INIT;
            end
            S_SCAN_INIT: begin
                o_dp_cmd.op = OP_SCAN_CLR;
                n_cnt       = '0;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                // one slot read per cycle; the compare works on the registered read data
                o_dp_cmd.op    = OP_SCAN_ACT;
                o_dp_cmd.rd_en = !scan_end;
                n_cnt          = r_cnt + 1'b1;
                if (scan_end) begin
                    n_state = S_RES;
                    case (i_dp_sts.cmd)
                        CMD_ADD:  n_res = RES_ADD;
                        CMD_NEXT: n_res = RES_NEXT;
                        default:  n_res = RES_INS;
                    endcase
                end
            end
            S_ROLL: begin
                o_dp_cmd.op = OP_ROLL_SET;
                n_cnt       = '0;
                n_state     = S_DSCAN;
            end
            S_DSCAN: begin
                o_dp_cmd.op    = OP_SCAN_DUE;
                o_dp_cmd.rd_en = !scan_end;
                n_cnt          = r_cnt + 1'b1;
                if (scan_end) begin
                    n_state = S_DCHK;
                end
            end
            S_DCHK: begin
                if (!i_dp_sts.due_any) begin
                    n_res   = RES_EMPTY;
                    n_state = S_RES;
                end else begin
                    n_state = S_SEL_INIT;
                end
            end
            S_SEL_INIT: begin
                o_dp_cmd.op = OP_SCAN_CLR;
                n_cnt       = '0;
                n_state     = S_SEL;
            end
            S_SEL: begin
                o_dp_cmd.op    = OP_SCAN_REM;
                o_dp_cmd.rd_en = !scan_end;
                n_cnt          = r_cnt + 1'b1;
                if (scan_end) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_dp_cmd.op = OP_PICK;
                n_state     = S_PCHK;
            end
            S_PCHK: begin
                // stop at the list limit; leftover due slots stay untouched
                if (i_dp_sts.due_any && i_dp_sts.nlist != NLIST_W'(MAX_OUT)) begin
                    n_state = S_SEL_INIT;
                end else begin
                    n_k     = '0;
                    n_state = S_RR;
                end
            end
            S_RR: begin
                o_dp_cmd.op = OP_REARM_RD;
                n_state     = S_RW;
            end
            S_RW: begin
                o_dp_cmd.op = OP_REARM_WR;
                if (k_last) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_RR;
                end
            end
            S_EMIT: begin
                if (i_dp_sts.out_free) begin
                    o_dp_cmd.op = OP_EMIT;
                    n_k         = r_k + 1'b1;
                    if (k_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RES: begin
                if (i_dp_sts.out_free) begin
                    o_dp_cmd.op = OP_RES;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
